/* hw/rtl/ihd_pkg.sv */
// Shared types, widths and constants for the 2x2 box-filter half-size downsampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ihd_pkg;

    // Pixel and sum widths
    localparam int PIX_W  = 8;
    localparam int PAIR_W = 9;
    localparam int SUM_W  = 10;

    // Configuration register widths and the write port data width
    localparam int IMAGE_COLS_W = 11;
    localparam int IMAGE_ROWS_W = 13;
    localparam int CFG_DATA_W   = 13;

    // Row counting: the frame height is capped at 4096 lines
    localparam int                    ROW_CNT_W = 12;
    localparam logic [IMAGE_ROWS_W-1:0] MAX_ROWS = 13'd4096;

    // Default line length limit handed to the top level
    localparam int DEF_MAX_COLS = 1024;

    // Register values after reset
    localparam logic [IMAGE_COLS_W-1:0] IMAGE_COLS_RST = 11'd2;
    localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_RST = 13'd2;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_COLS = 1'b0,
        CFG_IMAGE_ROWS = 1'b1
    } t_cfg_reg;

    // What the scan controller decides for one accepted item
    typedef struct packed {
        logic emit;   // item completes a 2x2 block: read the line entry
        logic store;  // item completes a pair on an even row: write the line entry
        logic last;   // the block is the final one of the frame
    } t_scan_op;

    // Rounded mean of four pixels, halves rounding up
    function automatic logic [PIX_W-1:0] avg4(input logic [SUM_W-1:0] sum);
        logic [SUM_W:0] rounded;
        rounded = {1'b0, sum} + (SUM_W+1)'(2);
        return rounded[SUM_W-1:2];
    endfunction

endpackage

/* hw/rtl/ihd_if.sv */
// Valid/ready stream interfaces for source pixels and downsampled results.
// Depends on ihd_pkg for field widths.
`timescale 1ns / 1ps

interface ihd_pix_if import ihd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ihd_res_if import ihd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             last_out;

    modport source (output valid, output out_pixel, output last_out, input ready);
    modport sink   (input valid, input out_pixel, input last_out, output ready);
endinterface

/* hw/rtl/ihd_line_buf.sv */
// Line buffer of horizontal pair sums: one write port, one read port, registered read data.
// Depends on ihd_pkg for the pair sum width.
`timescale 1ns / 1ps

module ihd_line_buf import ihd_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic                       i_rd_en,
    input  logic [((MAX_COLS/2 > 1) ? $clog2(MAX_COLS/2) : 1)-1:0] i_addr,
    input  logic [PAIR_W-1:0]          i_wr_data,
    output logic [PAIR_W-1:0]          o_rd_data
);

    localparam int PAIR_DEPTH = MAX_COLS / 2;

    logic [PAIR_W-1:0] r_mem [PAIR_DEPTH];
    logic [PAIR_W-1:0] r_rd_data;

    // Even rows write the pair sum of each column pair.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // Odd rows read the entry back; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/ihd_scan_ctrl.sv */
// Raster scan control: size registers, column and row counters, left pixel hold,
// and the per-item decision to store or emit. Depends on ihd_pkg.
`timescale 1ns / 1ps

module ihd_scan_ctrl import ihd_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  t_cfg_reg                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_accept,
    input  logic [PIX_W-1:0]          i_pixel,
    output t_scan_op                  o_op,
    output logic [((MAX_COLS/2 > 1) ? $clog2(MAX_COLS/2) : 1)-1:0] o_addr,
    output logic [PAIR_W-1:0]         o_pair
);

    localparam int CW         = $clog2(MAX_COLS) + 1;
    localparam int EW         = (CW > IMAGE_COLS_W) ? CW : IMAGE_COLS_W;
    localparam int PAIR_DEPTH = MAX_COLS / 2;
    localparam int AW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam logic [EW-1:0] MAX_COLS_E = EW'(MAX_COLS);

    logic [IMAGE_COLS_W-1:0] r_image_cols, n_image_cols;
    logic [IMAGE_ROWS_W-1:0] r_image_rows, n_image_rows;
    logic [CW-1:0]           r_col, n_col;
    logic [ROW_CNT_W-1:0]    r_row, n_row;
    logic [PIX_W-1:0]        r_left, n_left;

    logic [EW-1:0]           eff_cols;
    logic [IMAGE_ROWS_W-1:0] eff_rows;
    logic [EW-1:0]           col_e;
    logic [IMAGE_ROWS_W-1:0] row_e;
    logic                    in_range;
    logic                    col_end;
    logic                    row_end;
    logic [CW-1:0]           half_col;

    // Configuration writes.
    always_comb begin
        n_image_cols = r_image_cols;
        n_image_rows = r_image_rows;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_COLS: n_image_cols = i_cfg_data[IMAGE_COLS_W-1:0];
                CFG_IMAGE_ROWS: n_image_rows = i_cfg_data[IMAGE_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize is clamped.
    always_comb begin
        eff_cols = EW'(r_image_cols);
        if (r_image_cols == '0) begin
            eff_cols = EW'(1);
        end else if (eff_cols > MAX_COLS_E) begin
            eff_cols = MAX_COLS_E;
        end
        eff_rows = r_image_rows;
        if (r_image_rows == '0) begin
            eff_rows = IMAGE_ROWS_W'(1);
        end else if (r_image_rows > MAX_ROWS) begin
            eff_rows = MAX_ROWS;
        end
    end

    // Position tests for the current item.
    assign col_e    = EW'(r_col);
    assign row_e    = IMAGE_ROWS_W'(r_row);
    assign in_range = (col_e < eff_cols) && (row_e < eff_rows);
    assign col_end  = (col_e + EW'(1)) >= eff_cols;
    assign row_end  = (row_e + IMAGE_ROWS_W'(1)) >= eff_rows;
    assign half_col = r_col >> 1;

    // Odd columns close a pair: even rows store it, odd rows emit a block.
    always_comb begin
        o_op.store = in_range && r_col[0] && !r_row[0];
        o_op.emit  = in_range && r_col[0] && r_row[0];
        o_op.last  = ((EW'(half_col) + EW'(1)) == (eff_cols >> 1))
                  && ((IMAGE_ROWS_W'(r_row >> 1) + IMAGE_ROWS_W'(1)) == (eff_rows >> 1));
    end

    assign o_addr = half_col[AW-1:0];
    assign o_pair = PAIR_W'(r_left) + PAIR_W'(i_pixel);

    // Counter advance and left pixel capture on each accepted item.
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (i_accept) begin
            if (in_range && !r_col[0]) begin
                n_left = i_pixel;
            end
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + ROW_CNT_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= IMAGE_COLS_RST;
            r_image_rows <= IMAGE_ROWS_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
        end else begin
            r_image_cols <= n_image_cols;
            r_image_rows <= n_image_rows;
            r_col        <= n_col;
            r_row        <= n_row;
            r_left       <= n_left;
        end
    end

endmodule

/* hw/rtl/image_half_downsample_unit.sv */
// Top level of the 2x2 box-filter half-size downsampler.
// Depends on ihd_pkg, ihd_if, ihd_scan_ctrl and ihd_line_buf.
//
//   Channel  Dir  Signals                         Moves
//   i_pix    in   valid ready pixel               one source pixel per item
//   o_res    out  valid ready out_pixel last_out  one averaged pixel per item
//   cfg      in   i_cfg_we i_cfg_idx i_cfg_data   image_cols, image_rows writes
//
// One source pixel is taken per clock unless input is refused. A result moves
// from the pixel that completes its block through the registered read of the
// line buffer, held beside the block stage, then the output register. Synchronous
// active-low reset clears the counters and sets the frame size to 2x2; the line
// buffer needs no clearing. A stalled output holds the result and the pending
// block, and input is refused only while both are full.
`timescale 1ns / 1ps

module image_half_downsample_unit import ihd_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ihd_pix_if.sink               i_pix,
    ihd_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PAIR_DEPTH = MAX_COLS / 2;
    localparam int AW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

    t_scan_op          op;
    logic [AW-1:0]     addr;
    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] rd_data;
    logic              accept;
    logic              in_ready;
    logic              out_load;
    logic              s1_adv;
    logic              wr_en;
    logic              rd_en;
    logic [SUM_W-1:0]  block_sum;

    logic              r_s1_vld, n_s1_vld;
    logic [PAIR_W-1:0] r_s1_pair, n_s1_pair;
    logic              r_s1_last, n_s1_last;
    logic              r_out_vld, n_out_vld;
    logic [PIX_W-1:0]  r_out_pixel, n_out_pixel;
    logic              r_out_last, n_out_last;

    // Handshake: the output register frees the block stage, which frees the input.
    assign out_load = !r_out_vld || o_res.ready;
    assign s1_adv   = r_s1_vld && out_load;
    assign in_ready = !r_s1_vld || out_load;
    assign accept   = i_pix.valid && in_ready;
    assign wr_en    = accept && op.store;
    assign rd_en    = accept && op.emit;

    assign i_pix.ready = in_ready;

    ihd_scan_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pix.pixel),
        .o_op       (op),
        .o_addr     (addr),
        .o_pair     (pair)
    );

    // A line entry is always written a full row before it is read back, so
    // the read and the write of one entry never overlap.
    ihd_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (addr),
        .i_wr_data (pair),
        .o_rd_data (rd_data)
    );

    // Block stage: holds the lower pair sum while the upper one is read.
    always_comb begin
        n_s1_vld  = r_s1_vld;
        n_s1_pair = r_s1_pair;
        n_s1_last = r_s1_last;
        if (accept) begin
            n_s1_vld = op.emit;
            if (op.emit) begin
                n_s1_pair = pair;
                n_s1_last = op.last;
            end
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
    end

    assign block_sum = SUM_W'(rd_data) + SUM_W'(r_s1_pair);

    // Output register.
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_pixel = r_out_pixel;
        n_out_last  = r_out_last;
        if (s1_adv) begin
            n_out_vld   = 1'b1;
            n_out_pixel = avg4(block_sum);
            n_out_last  = r_s1_last;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pair   <= n_s1_pair;
        r_s1_last   <= n_s1_last;
        r_out_pixel <= n_out_pixel;
        r_out_last  <= n_out_last;
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.out_pixel = r_out_pixel;
    assign o_res.last_out  = r_out_last;

    // An item never both stores and reads the line buffer.
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("line buffer read and write in one cycle");

    // Every line read brings a pending block into the block stage.
    a_rd_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_s1_vld)
        else $error("line read without a pending block");

    // A pending block that cannot move blocks the input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !o_res.ready) |-> !i_pix.ready)
        else $error("input taken while both stages are full");

    // A block leaving the stage shows up as a valid result next cycle.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("block lost between stage and output register");

endmodule
